@@ hdl/pphp_pkg.sv @@
// Shared types and constants for the PID position controller with H-bridge PWM output.
package pphp_pkg;

	localparam int GAIN_FRAC_BITS = 24;
	localparam int POSITION_BITS  = 32;
	localparam int EF_W = (POSITION_BITS >= 32) ? POSITION_BITS + 1 : 33;

	localparam logic [63:0] TERM_CAP  = 64'h1000_0000_0000_0000;
	localparam logic [31:0] US_PER_S  = 32'd1000000;
	localparam logic [12:0] RECIP100_S = 13'd5243;     // 2^19/100, rounded up
	localparam logic [25:0] RECIP100_L = 26'd42949673; // 2^32/100, rounded up
	localparam logic [28:0] RECIP1M    = 29'd281474977; // 2^48/10^6, rounded up
	localparam logic [6:0]  DIV_STEPS = 7'd64;
	localparam logic [6:0]  DIV_STEPS_I = 7'd16;       // eight byte digits, each a quotient-digit and a remainder step

	typedef enum logic [2:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_DUTY_FLOOR,
		REG_DUTY_CEIL,
		REG_DEADBAND,
		REG_PWM_PERIOD
	} reg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_EDGE, OP_LOAD, OP_ERR, OP_MEDT, OP_ACC, OP_PMUL, OP_PTERM,
		OP_MLO, OP_MHI, OP_MADD, OP_DINIT, OP_DITER, OP_TERM, OP_DSCALE, OP_DLOAD,
		OP_SPEED, OP_DUTY1, OP_DUTY2, OP_DUTY3, OP_DUTY4
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_ERR, ST_MEDT, ST_ACC, ST_PMUL, ST_PTERM, ST_MLO, ST_MHI, ST_MADD,
		ST_DINIT, ST_DITER, ST_TERM, ST_DSCALE, ST_DLOAD, ST_SPEED, ST_DUTY1, ST_DUTY2,
		ST_DUTY3, ST_DUTY4, ST_DONE
	} state_t;

	typedef struct packed {
		op_t  op;
		logic term_d;
	} cmd_t;

	typedef struct packed {
		logic dt_zero;
		logic div_last;
	} stat_t;

	typedef struct packed {
		logic [31:0] gain_p;
		logic [31:0] gain_i;
		logic [31:0] gain_d;
		logic [6:0]  duty_floor;
		logic [6:0]  duty_ceil;
		logic [15:0] deadband;
		logic [15:0] period;
	} cfg_t;

	typedef struct packed {
		logic        running;
		logic [15:0] duty_negative;
		logic [15:0] duty_positive;
		logic [7:0]  speed_pct;
		logic [31:0] error_pulses;
		logic        direction_negative;
		logic [31:0] position;
	} res_t;

endpackage

@@ hdl/pphp_ctrl.sv @@
// Sequencer for encoder edges and the PID tick computation.
module pphp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_kind,
	input  logic             out_free,
	input  pphp_pkg::stat_t  stat,
	output logic             in_ready,
	output logic             out_load,
	output pphp_pkg::cmd_t   cmd
);
	import pphp_pkg::*;

	state_t state_q, state_d;
	logic   term_d_q, term_d_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			term_d_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			term_d_q <= term_d_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		term_d_d   = term_d_q;
		in_ready   = 1'b0;
		out_load   = 1'b0;
		cmd.op     = OP_NONE;
		cmd.term_d = term_d_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = in_kind ? OP_LOAD : OP_EDGE;
					state_d = in_kind ? ST_ERR : ST_DONE;
				end
			end
			ST_ERR: begin
				cmd.op  = OP_ERR;
				state_d = ST_MEDT;
			end
			ST_MEDT: begin
				cmd.op  = OP_MEDT;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.op  = OP_ACC;
				state_d = ST_PMUL;
			end
			ST_PMUL: begin
				cmd.op  = OP_PMUL;
				state_d = ST_PTERM;
			end
			ST_PTERM: begin
				cmd.op   = OP_PTERM;
				term_d_d = 1'b0;
				state_d  = ST_MLO;
			end
			ST_MLO: begin
				cmd.op  = OP_MLO;
				state_d = ST_MHI;
			end
			ST_MHI: begin
				cmd.op  = OP_MHI;
				state_d = ST_MADD;
			end
			ST_MADD: begin
				cmd.op  = OP_MADD;
				state_d = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.op  = OP_DINIT;
				state_d = ST_DITER;
			end
			ST_DITER: begin
				cmd.op = OP_DITER;
				if (stat.div_last) begin
					state_d = ST_TERM;
				end
			end
			ST_TERM: begin
				cmd.op  = OP_TERM;
				state_d = (!term_d_q && !stat.dt_zero) ? ST_DSCALE : ST_SPEED;
			end
			ST_DSCALE: begin
				cmd.op  = OP_DSCALE;
				state_d = ST_DLOAD;
			end
			ST_DLOAD: begin
				cmd.op   = OP_DLOAD;
				term_d_d = 1'b1;
				state_d  = ST_MLO;
			end
			ST_SPEED: begin
				cmd.op  = OP_SPEED;
				state_d = ST_DUTY1;
			end
			ST_DUTY1: begin
				cmd.op  = OP_DUTY1;
				state_d = ST_DUTY2;
			end
			ST_DUTY2: begin
				cmd.op  = OP_DUTY2;
				state_d = ST_DUTY3;
			end
			ST_DUTY3: begin
				cmd.op  = OP_DUTY3;
				state_d = ST_DUTY4;
			end
			ST_DUTY4: begin
				cmd.op  = OP_DUTY4;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/pphp_datapath.sv @@
// Position counter, PID arithmetic, shared multiplier and divider, duty mapping.
module pphp_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  pphp_pkg::cmd_t      cmd,
	input  pphp_pkg::cfg_t      cfg,
	input  logic                enc_a,
	input  logic                enc_b,
	input  logic signed [15:0]  target_position,
	input  logic [31:0]         elapsed_us,
	output pphp_pkg::stat_t     stat,
	output pphp_pkg::res_t      res
);
	import pphp_pkg::*;

	localparam logic signed [EF_W-1:0] E_MAX = EF_W'(signed'(32'h7FFF_FFFF));
	localparam logic signed [EF_W-1:0] E_MIN = EF_W'(signed'(32'h8000_0000));

	// architectural state
	logic [POSITION_BITS-1:0] pos_q;
	logic                     dir_q;
	logic signed [31:0]       prior_q;
	logic signed [63:0]       acc_q;
	logic [15:0]              dp_q, dn_q;
	logic                     run_q;
	logic signed [7:0]        speed_q;

	// working registers
	logic signed [15:0] target_q;
	logic [31:0]        dt_q;
	logic signed [31:0] e_q;
	logic [31:0]        e_mag_q;
	logic signed [32:0] diff_q;
	logic [31:0]        diff_mag_q;
	logic [63:0]        mp_q, opb_q, dq_q;
	logic [95:0]        num_q;
	logic [31:0]        rem_q;
	logic [6:0]         cnt_q;
	logic               cap_q;
	logic signed [63:0] sum_q;
	logic [6:0]         smag_q, pct_q;
	logic [13:0]        m_q;
	logic               span_neg_q;
	logic [22:0]        x_q;
	logic [27:0]        dig_t_q;
	logic [7:0]         dig_q_q;

	logic signed [EF_W-1:0] e_full;
	logic signed [31:0]     e_sat;
	logic signed [32:0]     diff_n;
	logic [31:0]            e_mag_n, diff_mag_n, mul_a, mul_b, ga, divisor;
	logic                   mul_en;
	logic signed [64:0]     prod65;
	logic signed [65:0]     acc_sum;
	logic [63:0]            qv, pv, acc_mag, sum_mag;
	logic [63-GAIN_FRAC_BITS:0] um;
	logic [6:0]             s_n, q_small;
	logic signed [7:0]      span;
	logic [26:0]            m_prod;
	logic [7:0]             pct_n;
	logic [48:0]            x_prod;
	logic [16:0]            d_n;
	logic [15:0]            d_sat;
	logic [32:0]            r2;
	logic                   sgn;
	logic [63:0]            pos_ext;
	logic [27:0]            dig_t;
	logic [56:0]            dig_prod;

	assign e_full     = EF_W'(target_q) - EF_W'($signed(pos_q));
	assign e_sat      = (e_full > E_MAX) ? 32'sh7FFF_FFFF :
	                    (e_full < E_MIN) ? $signed(32'h8000_0000) : e_full[31:0];
	assign diff_n     = 33'(e_sat) - 33'(prior_q);
	assign e_mag_n    = e_sat[31] ? 32'd0 - e_sat : e_sat;
	assign diff_mag_n = diff_n[32] ? 32'(33'd0 - diff_n) : diff_n[31:0];

	assign ga      = cmd.term_d ? cfg.gain_d : cfg.gain_i;
	assign divisor = cmd.term_d ? dt_q : US_PER_S;

	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (cmd.op)
			OP_MEDT: begin
				mul_a = e_mag_q;
				mul_b = dt_q;
			end
			OP_PMUL: begin
				mul_a = cfg.gain_p;
				mul_b = e_mag_q;
			end
			OP_MLO: begin
				mul_a = ga;
				mul_b = opb_q[31:0];
			end
			OP_MHI: begin
				mul_a = ga;
				mul_b = opb_q[63:32];
			end
			OP_DSCALE: begin
				mul_a = US_PER_S;
				mul_b = diff_mag_q;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	assign prod65  = e_q[31] ? -$signed({1'b0, mp_q}) : $signed({1'b0, mp_q});
	assign acc_sum = 66'(acc_q) + 66'(prod65);
	assign acc_mag = acc_q[63] ? 64'd0 - acc_q : acc_q;
	assign pv      = (mp_q > TERM_CAP) ? TERM_CAP : mp_q;
	assign qv      = (cap_q || dq_q > TERM_CAP) ? TERM_CAP : dq_q;
	assign sgn     = cmd.term_d ? diff_q[32] : acc_q[63];
	assign r2      = {rem_q, dq_q[63]};

	// divide by 10^6 one byte digit at a time: remainder below 10^6 plus next byte
	assign dig_t    = {rem_q[19:0], dq_q[63:56]};
	assign dig_prod = dig_t * RECIP1M;

	assign sum_mag = sum_q[63] ? 64'd0 - sum_q : sum_q;
	assign um      = sum_mag[63:GAIN_FRAC_BITS];
	assign s_n     = (um > (64-GAIN_FRAC_BITS)'(100)) ? 7'd100 : um[6:0];

	assign span    = $signed({1'b0, cfg.duty_ceil}) - $signed({1'b0, cfg.duty_floor});
	assign m_prod  = m_q * RECIP100_S;
	assign q_small = m_prod[25:19];
	assign pct_n   = span_neg_q ? {1'b0, cfg.duty_floor} - {1'b0, q_small}
	                            : {1'b0, cfg.duty_floor} + {1'b0, q_small};
	assign x_prod  = x_q * RECIP100_L;
	assign d_n     = x_prod[48:32];
	assign d_sat   = d_n[16] ? 16'hFFFF : d_n[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			dir_q   <= 1'b0;
			prior_q <= '0;
			acc_q   <= '0;
			dp_q    <= '0;
			dn_q    <= '0;
			run_q   <= 1'b0;
			speed_q <= '0;
			cnt_q   <= '0;
		end else begin
			case (cmd.op)
				OP_EDGE: begin
					if (enc_a == enc_b) begin
						pos_q <= pos_q + 1'b1;
						dir_q <= 1'b0;
					end else begin
						pos_q <= pos_q - 1'b1;
						dir_q <= 1'b1;
					end
				end
				OP_ACC: begin
					if (acc_sum > 66'(signed'(64'h7FFF_FFFF_FFFF_FFFF))) begin
						acc_q <= 64'sh7FFF_FFFF_FFFF_FFFF;
					end else if (acc_sum < 66'(signed'(64'h8000_0000_0000_0000))) begin
						acc_q <= $signed(64'h8000_0000_0000_0000);
					end else begin
						acc_q <= acc_sum[63:0];
					end
				end
				OP_DINIT: begin
					cnt_q <= cmd.term_d ? DIV_STEPS : DIV_STEPS_I;
				end
				OP_DITER: begin
					cnt_q <= cnt_q - 1'b1;
				end
				OP_SPEED: begin
					if (e_mag_q < 32'(cfg.deadband)) begin
						speed_q <= '0;
					end else begin
						speed_q <= sum_q[63] ? 8'sd0 - $signed({1'b0, s_n})
						                     : $signed({1'b0, s_n});
					end
				end
				OP_DUTY4: begin
					prior_q <= e_q;
					if (speed_q > 8'sd0) begin
						dp_q  <= d_sat;
						dn_q  <= '0;
						run_q <= 1'b1;
					end else if (speed_q < 8'sd0) begin
						dp_q  <= '0;
						dn_q  <= d_sat;
						run_q <= 1'b1;
					end else begin
						dp_q  <= '0;
						dn_q  <= '0;
						run_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			mp_q <= mul_a * mul_b;
		end
		case (cmd.op)
			OP_LOAD: begin
				target_q <= target_position;
				dt_q     <= elapsed_us;
			end
			OP_ERR: begin
				e_q        <= e_sat;
				e_mag_q    <= e_mag_n;
				diff_q     <= diff_n;
				diff_mag_q <= diff_mag_n;
			end
			OP_PMUL: begin
				opb_q <= acc_mag;
			end
			OP_PTERM: begin
				sum_q <= e_q[31] ? 64'sd0 - $signed(pv) : $signed(pv);
			end
			OP_MHI: begin
				num_q <= {32'd0, mp_q};
			end
			OP_MADD: begin
				num_q <= num_q + {mp_q, 32'd0};
			end
			OP_DINIT: begin
				cap_q <= num_q[95:64] >= divisor;
				rem_q <= num_q[95:64];
				dq_q  <= num_q[63:0];
			end
			OP_DITER: begin
				if (cmd.term_d) begin
					if (r2 >= {1'b0, divisor}) begin
						rem_q <= 32'(r2 - {1'b0, divisor});
						dq_q  <= {dq_q[62:0], 1'b1};
					end else begin
						rem_q <= r2[31:0];
						dq_q  <= {dq_q[62:0], 1'b0};
					end
				end else if (!cnt_q[0]) begin
					dig_t_q <= dig_t;
					dig_q_q <= dig_prod[55:48];
				end else begin
					rem_q <= {12'd0, 20'(dig_t_q - 28'(dig_q_q) * US_PER_S[27:0])};
					dq_q  <= {dq_q[55:0], dig_q_q};
				end
			end
			OP_TERM: begin
				sum_q <= sum_q + (sgn ? 64'sd0 - $signed(qv) : $signed(qv));
			end
			OP_DLOAD: begin
				opb_q <= mp_q;
			end
			OP_SPEED: begin
				smag_q <= (e_mag_q < 32'(cfg.deadband)) ? 7'd0 : s_n;
			end
			OP_DUTY1: begin
				m_q        <= smag_q * (span[7] ? 7'(8'sd0 - span) : span[6:0]);
				span_neg_q <= span[7];
			end
			OP_DUTY2: begin
				pct_q <= pct_n[6:0];
			end
			OP_DUTY3: begin
				x_q <= cfg.period * pct_q;
			end
			default: begin
			end
		endcase
	end

	assign stat.dt_zero  = (dt_q == 32'd0);
	assign stat.div_last = (cnt_q == 7'd1);

	assign pos_ext                = 64'(pos_q);
	assign res.position           = pos_ext[31:0];
	assign res.direction_negative = dir_q;
	assign res.error_pulses       = prior_q;
	assign res.speed_pct          = speed_q;
	assign res.duty_positive      = dp_q;
	assign res.duty_negative      = dn_q;
	assign res.running            = run_q;

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(dp_q != 16'd0 && dn_q != 16'd0)) else $error("both bridge sides driven");
	a_run_speed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_NONE |-> run_q == (speed_q != 8'sd0))
		else $error("run flag disagrees with speed");
	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		speed_q <= 8'sd100 && speed_q >= -8'sd100) else $error("speed out of range");
	a_edge_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EDGE |=> (pos_q == $past(pos_q) + 1'b1 || pos_q == $past(pos_q) - 1'b1))
		else $error("edge did not move position by one");

endmodule

@@ hdl/pid_position_hbridge_pwm.sv @@
// Top level: stream ports, configuration registers and output register.
// An encoder edge goes to ST_DONE; its result loads when the output register is free.
// A control tick runs the P, I and D terms through the shared multiplier and divider; the D
// term is skipped when elapsed_us is 0. The one-bit-per-cycle divider runs 64 steps for
// the D term; the I term divides by 10^6 one byte digit at a time.
// One transaction at a time; a new one is accepted while a result waits in the output register.
// arst_n clears position, PID state and duties and loads the register defaults.
module pid_position_hbridge_pwm (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [55:0]  s_axis_tdata,  // enc_a, enc_b, target_position[15:0], elapsed_us[31:0], zero pad
	input  logic         s_axis_tuser,  // kind
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [111:0] m_axis_tdata,  // position[31:0], direction_negative, error_pulses[31:0],
	                                    // speed_pct[7:0], duty_positive[15:0], duty_negative[15:0],
	                                    // running, zero pad
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import pphp_pkg::*;

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;
	res_t  res, out_q;
	logic  out_valid_q, out_free, out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p     <= 32'd8388608;
			cfg_q.gain_i     <= 32'd1678;
			cfg_q.gain_d     <= 32'd838861;
			cfg_q.duty_floor <= 7'd20;
			cfg_q.duty_ceil  <= 7'd100;
			cfg_q.deadband   <= 16'd6;
			cfg_q.period     <= 16'd1000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_P:     cfg_q.gain_p     <= cfg_data;
				REG_GAIN_I:     cfg_q.gain_i     <= cfg_data;
				REG_GAIN_D:     cfg_q.gain_d     <= cfg_data;
				REG_DUTY_FLOOR: cfg_q.duty_floor <= cfg_data[6:0];
				REG_DUTY_CEIL:  cfg_q.duty_ceil  <= cfg_data[6:0];
				REG_DEADBAND:   cfg_q.deadband   <= cfg_data[15:0];
				REG_PWM_PERIOD: cfg_q.period     <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	pphp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_kind  (s_axis_tuser),
		.out_free (out_free),
		.stat     (stat),
		.in_ready (s_axis_tready),
		.out_load (out_load),
		.cmd      (cmd)
	);

	pphp_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg             (cfg_q),
		.enc_a           (s_axis_tdata[0]),
		.enc_b           (s_axis_tdata[1]),
		.target_position ($signed(s_axis_tdata[17:2])),
		.elapsed_us      (s_axis_tdata[49:18]),
		.stat            (stat),
		.res             (res)
	);

	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_q};

endmodule
